FILE: hdl/bdq_pkg.sv
package bdq_pkg;

    // Number of byte cells in the row
    localparam int DEPTH = 16;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int OUT_W = 5;
    // Common width for comparing the fill level against the capacity
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_FLUSH      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHR,
        CELL_SHL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [CNT_W-1:0] fill;
    } cell_ctrl_t;

endpackage

FILE: hdl/bdq_if.sv
interface bdq_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface bdq_res_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] data_out;
    logic [4:0] count;
    logic [4:0] room;

    modport source (output valid, output ok, output data_out, output count, output room,
                    input ready);
    modport sink   (input valid, input ok, input data_out, input count, input room,
                    output ready);
endinterface

FILE: hdl/bdq_cell.sv
module bdq_cell (
    input  logic                          clk,
    input  bdq_pkg::cell_ctrl_t           ctrl,
    input  logic [bdq_pkg::IDX_W-1:0]     idx,
    input  logic [7:0]                    load_data,
    input  logic [7:0]                    left_data,
    input  logic [7:0]                    right_data,
    output logic [7:0]                    data,
    output logic [7:0]                    tap
);

    logic [7:0] data_reg;
    logic       is_tail;
    logic       is_back;

    // Tail: first free slot; back: last held byte
    assign is_tail = (bdq_pkg::CNT_W'(idx) == ctrl.fill);
    assign is_back = ((bdq_pkg::CNT_W'(idx) + bdq_pkg::CNT_W'(1)) == ctrl.fill);

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            bdq_pkg::CELL_LOAD:
            begin
                if (is_tail)
                begin
                    data_reg <= load_data;
                end
            end
            bdq_pkg::CELL_SHR: data_reg <= left_data;
            bdq_pkg::CELL_SHL: data_reg <= right_data;
            default:           data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;
    assign tap  = is_back ? data_reg : 8'd0;

endmodule

FILE: hdl/byte_deque_unit.sv
// Double-ended byte queue built as a row of byte cells.
//
// Channels: cmd (sink) carries op and data_in; res (source) carries ok,
// data_out, count and room. A transfer happens on a rising clk edge with
// valid and ready both high. cfg_we/cfg_wdata write the capacity register
// (5 bits, reset 16); write it only while the queue is idle.
//
// The queue always sits packed at the low end of the row: cell 0 holds the
// front byte, cell count-1 the back byte. Push back loads the first free
// cell, push front shifts the whole row up by one, pop front shifts it down
// by one, pop back reads the back cell through an OR of one-hot taps.
//
// The result is registered and appears in the cycle after the command transfer.
// Throughput: one command per clock while res is not held off, set by the
// update of the fill counter and the one-step shift of the cell row.
// Reset: fill and the result valid flag clear, capacity returns to 16; the
// cell contents are not cleared and are never read before being written.
// Stall: while res is held off, the result register keeps its item and
// cmd.ready follows res.ready, so nothing is lost or repeated.
module byte_deque_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    bdq_cmd_if.sink                       cmd,
    bdq_res_if.source                     res,
    input  logic                          cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]     cfg_wdata
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int CMP_W = bdq_pkg::CMP_W;
    localparam int OUT_W = bdq_pkg::OUT_W;

    logic [bdq_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [CNT_W-1:0]          fill_next;

    logic                      res_valid_reg;
    logic                      ok_reg;
    logic                      ok_next;
    logic [7:0]                dout_reg;
    logic [7:0]                dout_next;
    logic [OUT_W-1:0]          count_reg;
    logic [OUT_W-1:0]          room_reg;
    logic [OUT_W-1:0]          room_next;

    logic                      cmd_fire;
    logic [CMP_W-1:0]          cap_eff;
    logic [CMP_W-1:0]          fill_ext;
    logic [CMP_W-1:0]          fill_next_ext;
    logic                      can_push;
    logic                      can_pop;
    bdq_pkg::op_t              op;
    bdq_pkg::cell_ctrl_t       cell_ctrl;

    logic [7:0]                cell_data [DEPTH];
    logic [7:0]                cell_tap  [DEPTH];
    logic [7:0]                back_byte;

    // Accept whenever the result register is empty or being drained
    assign cmd.ready = !res_valid_reg || res.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign op        = bdq_pkg::op_t'(cmd.op);

    // Saturate the configured capacity at the row length
    assign cap_eff  = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign can_push = (fill_ext < cap_eff);
    assign can_pop  = (fill_reg != '0);

    // Gather the back byte from the one-hot cell taps
    always_comb
    begin
        back_byte = 8'd0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_byte = back_byte | cell_tap[i];
        end
    end

    // Decode the command: next fill, result and cell row action
    always_comb
    begin
        fill_next     = fill_reg;
        ok_next       = 1'b0;
        dout_next     = 8'd0;
        cell_ctrl.cmd = bdq_pkg::CELL_HOLD;
        cell_ctrl.fill = fill_reg;
        if (cmd_fire)
        begin
            unique case (op)
                bdq_pkg::OP_PUSH_BACK:
                begin
                    if (can_push)
                    begin
                        cell_ctrl.cmd = bdq_pkg::CELL_LOAD;
                        fill_next     = fill_reg + CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                bdq_pkg::OP_POP_BACK:
                begin
                    if (can_pop)
                    begin
                        dout_next = back_byte;
                        fill_next = fill_reg - CNT_W'(1);
                        ok_next   = 1'b1;
                    end
                end
                bdq_pkg::OP_PUSH_FRONT:
                begin
                    if (can_push)
                    begin
                        cell_ctrl.cmd = bdq_pkg::CELL_SHR;
                        fill_next     = fill_reg + CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                bdq_pkg::OP_POP_FRONT:
                begin
                    if (can_pop)
                    begin
                        cell_ctrl.cmd = bdq_pkg::CELL_SHL;
                        dout_next     = cell_data[0];
                        fill_next     = fill_reg - CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                bdq_pkg::OP_FLUSH:
                begin
                    fill_next = '0;
                    ok_next   = 1'b1;
                end
                default:
                begin
                    // Unknown op: drop it, report the unchanged state
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    assign fill_next_ext = CMP_W'(fill_next);
    assign room_next     = (fill_next_ext < cap_eff) ?
                           OUT_W'(cap_eff - fill_next_ext) : '0;

    // Cell row: cell 0 is the front; the push-front byte enters from the left end
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] left_data;
        logic [7:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cmd.data_in;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = 8'd0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .idx        (bdq_pkg::IDX_W'(i)),
            .load_data  (cmd.data_in),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bdq_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // Fill counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on each command transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            ok_reg    <= ok_next;
            dout_reg  <= dout_next;
            count_reg <= OUT_W'(fill_next);
            room_reg  <= room_next;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.ok       = ok_reg;
    assign res.data_out = dout_reg;
    assign res.count    = count_reg;
    assign res.room     = room_reg;

`ifndef SYNTH
    // A failed operation never returns a byte
    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !ok_reg) |-> (dout_reg == 8'd0))
        else $error("failed operation returned a byte");

    // The fill level never passes the row length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= CMP_W'(DEPTH))
        else $error("fill level beyond row length");

    // An accepted flush empties the queue
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && op == bdq_pkg::OP_FLUSH) |=> (fill_reg == '0))
        else $error("flush left bytes in the queue");

    // A successful push moves the fill level up by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && ok_next &&
         (op == bdq_pkg::OP_PUSH_BACK || op == bdq_pkg::OP_PUSH_FRONT))
        |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("push did not grow the queue by one");
`endif

endmodule
